@@ rtl/sha256_counter_mode_random_generator_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 counter-mode random generator package
// Round constants, initial hash value and shared sizes.
// ----------------------------------------------------------------------------
package scmrg_pkg;

	localparam int unsigned STIR_ROUNDS          = 8;
	localparam int unsigned RESEED_INTERVAL_BITS = 8;
	localparam int unsigned ROUND_W              = 4;

	localparam logic ACT_STIR     = 1'b0;
	localparam logic ACT_GENERATE = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_READY = 1'b1;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;
	typedef logic [15:0][31:0] block_t;

	function automatic word_t k_round(input logic [5:0] idx);
		word_t k;
		case (idx)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	localparam hash_t H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ rtl/scmrg_sha256_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 single-block compression core
// Runs one round per cycle on a 16-word rolling message schedule; adds the
// initial hash value at the end.
// ----------------------------------------------------------------------------
module scmrg_sha256_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  scmrg_pkg::block_t    block,
	output logic                 done,
	output scmrg_pkg::hash_t     digest
);
	import scmrg_pkg::*;

	block_t      w_q;
	hash_t       v_q;
	logic [5:0]  round_q;
	logic        busy_q;
	logic        fin_q;

	word_t a, b, c, d, e, f, g, h;
	word_t s0e, s1e, ch, mj, t1, t2, ws0, ws1, w_new;

	always_comb begin
		a = v_q[0]; b = v_q[1]; c = v_q[2]; d = v_q[3];
		e = v_q[4]; f = v_q[5]; g = v_q[6]; h = v_q[7];
		s1e = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
		ch  = (e & f) ^ (~e & g);
		t1  = h + s1e + ch + k_round(round_q) + w_q[0];
		s0e = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
		mj  = (a & b) ^ (a & c) ^ (b & c);
		t2  = s0e + mj;
		ws0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		ws1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + ws0 + w_q[9] + ws1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			round_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= block;
			v_q <= H_INIT;
		end else if (busy_q) begin
			w_q <= {w_new, w_q[15:1]};
			v_q <= {g, f, e, d + t1, c, b, a, t1 + t2};
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			digest[i] = v_q[i] + H_INIT[i];
		end
	end

	assign done = fin_q;

endmodule

@@ rtl/sha256_counter_mode_random_generator.sv @@
// SHA-256 counter-mode random generator.
// Stir: load, 64 rounds in a shared compression core (one per cycle), then
// digest capture into the seed. Generate: hash, then one word per cycle while
// the output is not stalled. A new request is taken only once the last result
// has been accepted. Not-ready and zero-count generates answer without hashing.
// Reset (arst_n low) clears seed, counter and rounds.
module sha256_counter_mode_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        clear_first,
	input  logic [63:0] entropy_tsc,
	input  logic [63:0] entropy_timer,
	input  logic [5:0]  byte_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] random_word,
	output logic        status,
	output logic        last_word
);
	import scmrg_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HASH = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]       state_q;
	logic [3:0][63:0] seed_q;
	logic [63:0]      ctr_q;
	logic [ROUND_W-1:0] rounds_q;
	logic             act_q;
	logic [63:0]      tsc_q, tmr_q;
	logic [5:0]       cnt_q;
	logic [1:0]       widx_q;
	logic [1:0]       nlast_q;
	logic [31:0][7:0] dig_q;
	logic             out_valid_q;
	logic [63:0]      word_q;
	logic             status_q, last_q;

	logic             core_start, core_done;
	block_t           blk;
	hash_t            digest;
	logic [3:0][63:0] seed_mix;
	logic [31:0][7:0] dig_b;
	logic             ready_gen;
	logic [5:0]       cnt_sat;

	scmrg_sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.block  (blk),
		.done   (core_done),
		.digest (digest)
	);

	assign ready_gen = (rounds_q >= ROUND_W'(STIR_ROUNDS));
	assign cnt_sat   = (byte_count > 6'd32) ? 6'd32 : byte_count;
	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign core_start = in_valid && in_ready &&
		((action == ACT_STIR) || (ready_gen && byte_count != 6'd0));

	// Message bytes: seed (then counter for generate), little-endian, then SHA padding
	always_comb begin
		logic [39:0][7:0] msg;
		seed_mix = seed_q;
		if (action == ACT_STIR && clear_first) begin
			seed_mix = '0;
		end
		seed_mix[0] = seed_mix[0] ^ entropy_tsc;
		seed_mix[1] = seed_mix[1] ^ entropy_timer;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 8; j++) begin
				msg[8*i+j] = (action == ACT_STIR) ? seed_mix[i][8*j +: 8]
					: seed_q[i][8*j +: 8];
			end
		end
		for (int j = 0; j < 8; j++) begin
			msg[32+j] = ctr_q[8*j +: 8];
		end
		blk = '0;
		for (int i = 0; i < 8; i++) begin
			blk[i] = {msg[4*i], msg[4*i+1], msg[4*i+2], msg[4*i+3]};
		end
		if (action == ACT_STIR) begin
			blk[8]  = 32'h8000_0000;
			blk[15] = 32'd256;
		end else begin
			blk[8]  = {msg[32], msg[33], msg[34], msg[35]};
			blk[9]  = {msg[36], msg[37], msg[38], msg[39]};
			blk[10] = 32'h8000_0000;
			blk[15] = 32'd320;
		end
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 4; j++) begin
				dig_b[4*i+j] = digest[i][31-8*j -: 8];
			end
		end
	end

	logic [63:0] ctr_inc;
	assign ctr_inc = ctr_q + 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= '0;
			ctr_q       <= '0;
			rounds_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in ST_OUT the output register is reloaded below instead
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (core_start) begin
							state_q <= ST_HASH;
							if (action == ACT_STIR) begin
								if (clear_first) begin
									ctr_q    <= '0;
									rounds_q <= '0;
								end
							end
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_HASH: begin
					if (core_done) begin
						if (act_q == ACT_STIR) begin
							for (int i = 0; i < 4; i++) begin
								seed_q[i] <= {dig_b[8*i+7], dig_b[8*i+6], dig_b[8*i+5],
									dig_b[8*i+4], dig_b[8*i+3], dig_b[8*i+2],
									dig_b[8*i+1], dig_b[8*i]};
							end
							if (rounds_q < ROUND_W'(STIR_ROUNDS)) begin
								rounds_q <= rounds_q + ROUND_W'(1);
							end
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							ctr_q <= ctr_inc;
							if (ctr_inc[RESEED_INTERVAL_BITS-1:0] == '0) begin
								seed_q[0] <= seed_q[0] ^ tsc_q;
								seed_q[1] <= seed_q[1] ^ tmr_q;
							end
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (widx_q == nlast_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q   <= action;
			tsc_q   <= entropy_tsc;
			tmr_q   <= entropy_timer;
			cnt_q   <= cnt_sat;
			nlast_q <= 2'((cnt_sat - 6'd1) >> 3);
			widx_q  <= '0;
			// short answers for stir and for generates that skip the hash
			word_q   <= '0;
			last_q   <= 1'b1;
			status_q <= (action == ACT_GENERATE && !ready_gen) ? STATUS_NOT_READY
				: STATUS_OK;
		end
		if (state_q == ST_HASH && core_done) begin
			dig_q  <= dig_b;
			word_q <= '0;
		end
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			for (int j = 0; j < 8; j++) begin
				word_q[8*j +: 8] <= ({widx_q, 3'(j)} < cnt_q[5:0] || cnt_q[5])
					? dig_q[{widx_q, 3'(j)}] : 8'h00;
			end
			status_q <= STATUS_OK;
			last_q   <= (widx_q == nlast_q);
			widx_q   <= widx_q + 2'd1;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = word_q;
	assign status      = status_q;
	assign last_word   = last_q;

endmodule

@@ tb/sv/tb_sha256_counter_mode_random_generator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 counter-mode random generator testbench
// Drives stir and generate requests with random gaps and output stalls,
// predicts every result word with a behavioral SHA-256 DRBG and checks them.
// ----------------------------------------------------------------------------
module tb_sha256_counter_mode_random_generator;
	import scmrg_pkg::*;

	typedef struct packed {
		logic        act;
		logic        clr;
		logic [63:0] tsc;
		logic [63:0] tmr;
		logic [5:0]  cnt;
		logic        drain;
	} req_t;

	typedef struct packed {
		logic [63:0] word;
		logic        stat;
		logic        last;
	} res_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic        clear_first;
	logic [63:0] entropy_tsc;
	logic [63:0] entropy_timer;
	logic [5:0]  byte_count;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] random_word;
	logic        status;
	logic        last_word;

	req_t pending_reqs[$];
	res_t expected_words[$];
	logic [63:0] seed_words[4];
	logic [63:0] blk_ctr;
	logic [3:0]  rounds_done;
	int          errors = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          hold_cnt = 0;
	int          accepted = 0;
	bit          hold_done = 0;
	bit          quiet = 0;

	sha256_counter_mode_random_generator u_top (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// single-block SHA-256 of len bytes, digest returned as bytes
	function automatic void sha_one(input logic [7:0] msg[40], input int len,
			output logic [7:0] dig[32]);
		logic [7:0]  blk[64];
		logic [31:0] w[64];
		logic [31:0] h[8];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		for (int i = 0; i < len; i++) blk[i] = msg[i];
		blk[len] = 8'h80;
		for (int i = 0; i < 8; i++) blk[63 - i] = 8'((len * 8) >> (8 * i));
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) h[i] = IV_TAB[i];
		a = h[0]; b = h[1]; c = h[2]; d = h[3];
		e = h[4]; f = h[5]; g = h[6]; hh = h[7];
		for (int i = 0; i < 64; i++) begin
			t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TAB[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			hh = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d;
		h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
		for (int i = 0; i < 32; i++) dig[i] = h[i/4][31 - 8*(i%4) -: 8];
	endfunction

	task automatic predict_drbg(input req_t r);
		logic [7:0] msg[40];
		logic [7:0] dig[32];
		res_t       res;
		int         cnt, nw;
		for (int i = 0; i < 40; i++) msg[i] = 8'h00;
		if (r.act == ACT_STIR) begin
			if (r.clr) begin
				for (int i = 0; i < 4; i++) seed_words[i] = '0;
				blk_ctr = '0;
				rounds_done = '0;
			end
			seed_words[0] ^= r.tsc;
			seed_words[1] ^= r.tmr;
			for (int i = 0; i < 32; i++) msg[i] = seed_words[i/8][8*(i%8) +: 8];
			sha_one(msg, 32, dig);
			for (int i = 0; i < 32; i++) seed_words[i/8][8*(i%8) +: 8] = dig[i];
			if (rounds_done < STIR_ROUNDS) rounds_done++;
			expected_words.push_back('{64'h0, STATUS_OK, 1'b1});
		end else if (rounds_done < STIR_ROUNDS) begin
			expected_words.push_back('{64'h0, STATUS_NOT_READY, 1'b1});
		end else if (r.cnt == 0) begin
			expected_words.push_back('{64'h0, STATUS_OK, 1'b1});
		end else begin
			cnt = (r.cnt > 32) ? 32 : r.cnt;
			for (int i = 0; i < 32; i++) msg[i] = seed_words[i/8][8*(i%8) +: 8];
			for (int i = 0; i < 8; i++) msg[32 + i] = blk_ctr[8*i +: 8];
			sha_one(msg, 40, dig);
			nw = (cnt + 7) / 8;
			for (int i = 0; i < nw; i++) begin
				res.word = '0;
				for (int j = 0; j < 8; j++)
					if (8*i + j < cnt) res.word[8*j +: 8] = dig[8*i + j];
				res.stat = STATUS_OK;
				res.last = (i + 1 == nw);
				expected_words.push_back(res);
			end
			blk_ctr++;
			if (blk_ctr[RESEED_INTERVAL_BITS-1:0] == '0) begin
				seed_words[0] ^= r.tsc;
				seed_words[1] ^= r.tmr;
			end
		end
	endtask

	function automatic req_t mk_req(logic act, logic clr, logic [5:0] cnt);
		req_t r;
		r.act = act;
		r.clr = clr;
		r.tsc = {$urandom, $urandom};
		r.tmr = {$urandom, $urandom};
		r.cnt = cnt;
		r.drain = 1'b0;
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_drbg({action, clear_first, entropy_tsc, entropy_timer,
					byte_count, 1'b0});
				accepted++;
			end
			if (in_valid && !in_ready) begin
				// hold the request until taken
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 &&
					!(pending_reqs[0].drain && (expected_words.size() > 0 ||
					(in_valid && in_ready)))) begin
				in_valid      <= 1'b1;
				action        <= pending_reqs[0].act;
				clear_first   <= pending_reqs[0].clr;
				entropy_tsc   <= pending_reqs[0].tsc;
				entropy_timer <= pending_reqs[0].tmr;
				byte_count    <= pending_reqs[0].cnt;
				void'(pending_reqs.pop_front());
				if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && accepted >= 150) begin
				hold_cnt = 400;
				hold_done = 1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 19);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result word=%h status=%b last=%b",
					$time, random_word, status, last_word);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (random_word !== want.word) begin
					$display("%0t: random_word expected %h actual %h",
						$time, want.word, random_word);
					errors++;
				end
				if (status !== want.stat) begin
					$display("%0t: status expected %b actual %b", $time, want.stat, status);
					errors++;
				end
				if (last_word !== want.last) begin
					$display("%0t: last_word expected %b actual %b",
						$time, want.last, last_word);
					errors++;
				end
			end
		end
	end

	initial begin
		req_t       r;
		int         roll;
		logic [5:0] corner_cnts[9];
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		out_ready     = 1'b0;
		action        = ACT_STIR;
		clear_first   = 1'b0;
		entropy_tsc   = '0;
		entropy_timer = '0;
		byte_count    = '0;
		for (int i = 0; i < 4; i++) seed_words[i] = '0;
		blk_ctr     = '0;
		rounds_done = '0;
		corner_cnts = '{6'd0, 6'd1, 6'd7, 6'd8, 6'd9, 6'd31, 6'd32, 6'd33, 6'd63};

		// generate before ready, then seed with extreme entropy
		pending_reqs.push_back(mk_req(ACT_GENERATE, 1'b0, 6'd32));
		r = mk_req(ACT_STIR, 1'b1, 6'd0);
		r.tsc = '0; r.tmr = '1;
		pending_reqs.push_back(r);
		r = mk_req(ACT_STIR, 1'b0, 6'd63);
		r.tsc = '1; r.tmr = '0;
		pending_reqs.push_back(r);
		for (int i = 0; i < 5; i++) pending_reqs.push_back(mk_req(ACT_STIR, 1'b0, 6'd5));
		pending_reqs.push_back(mk_req(ACT_GENERATE, 1'b0, 6'd8));
		pending_reqs.push_back(mk_req(ACT_STIR, 1'b0, 6'd0));
		foreach (corner_cnts[i])
			pending_reqs.push_back(mk_req(ACT_GENERATE, 1'b0, corner_cnts[i]));
		// extra stir saturates the round count
		pending_reqs.push_back(mk_req(ACT_STIR, 1'b0, 6'd0));

		// random part: mostly generates so the counter wraps its reseed interval
		for (int n = 0; n < 440; n++) begin
			roll = $urandom_range(0, 99);
			if (n > 320 && roll < 3) begin
				pending_reqs.push_back(mk_req(ACT_STIR, 1'b1, 6'($urandom)));
				for (int i = 0; i < 7; i++)
					pending_reqs.push_back(mk_req(ACT_STIR, 1'b0, 6'($urandom)));
				n += 7;
			end else if (roll < 10) begin
				pending_reqs.push_back(mk_req(ACT_STIR, 1'b0, 6'($urandom)));
			end else begin
				pending_reqs.push_back(mk_req(ACT_GENERATE, 1'b0,
					($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32))));
			end
			if (n == 250) begin
				r = mk_req(ACT_GENERATE, 1'b0, 6'd32);
				r.drain = 1'b1;
				pending_reqs.push_back(r);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_reqs.size() < 40);
		quiet = 1;
		wait (pending_reqs.size() == 0 && !in_valid && expected_words.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
